// ===== rtl/spadd_pkg.sv =====
package spadd_pkg;

  localparam int COEF_W = 32;
  localparam int EXP_W  = 31;
  localparam int SUM_W  = 33;

  typedef struct packed {
    logic                     avail;
    logic signed [COEF_W-1:0] coef;
    logic        [EXP_W-1:0]  expo;
  } head_t;

  typedef struct packed {
    logic                    take_a;
    logic                    take_b;
    logic                    nonzero;
    logic signed [SUM_W-1:0] coef;
    logic        [EXP_W-1:0] expo;
  } step_t;

endpackage

// ===== rtl/sorted_polynomial_add_core.sv =====
// Adds two sparse polynomials by merging their term lists. Terms are loaded one per cycle
// into two lists of up to DEPTH terms each (descending exponent); a term for a full list is
// dropped and flags overflow on every result of the next merge. The request marked tlast
// starts the merge: the PREP state fetches the list heads, then the MERGE state runs one
// step of the shared compare/add unit at a time (at most the sum of both list lengths
// steps, each held while a result waits on a stalled output) until it sees both lists
// exhausted, then the FINISH state sends the final term with tlast. Loading is blocked
// during the merge. Terms that sum to zero are dropped; if nothing survives a single result
// flagged empty is sent.
module sorted_polynomial_add_core #(
  parameter int DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // coefficient[31:0], exponent[62:32], zero
  input  logic [1:0]  s_tuser,   // which_list, has_term
  input  logic        s_tlast,   // end_of_load
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // sum_coefficient[32:0], result_exponent[63:33]
  output logic [1:0]  m_tuser,   // empty_res, overflow
  output logic        m_tlast    // last
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CE = spadd_pkg::COEF_W + spadd_pkg::EXP_W;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_PREP   = 2'd1;
  localparam logic [1:0] ST_MERGE  = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0]    st;
  logic [CE-1:0] mem_a [DEPTH];
  logic [CE-1:0] mem_b [DEPTH];
  logic [CE-1:0] rd_a;
  logic [CE-1:0] rd_b;
  logic [CW-1:0] cnt_a;
  logic [CW-1:0] cnt_b;
  logic [CW-1:0] i;
  logic [CW-1:0] j;
  logic [CW-1:0] i_next;
  logic [CW-1:0] j_next;
  logic          dropped;

  logic                                pend_valid;
  logic signed [spadd_pkg::SUM_W-1:0]  pend_coef;
  logic        [spadd_pkg::EXP_W-1:0]  pend_exp;

  logic                                out_valid;
  logic signed [spadd_pkg::SUM_W-1:0]  out_coef;
  logic        [spadd_pkg::EXP_W-1:0]  out_exp;
  logic                                out_last;
  logic                                out_empty;
  logic                                out_ovf;

  spadd_pkg::head_t head_a;
  spadd_pkg::head_t head_b;
  spadd_pkg::step_t step;

  logic in_acc;
  logic has_term;
  logic which;
  logic wr_a;
  logic wr_b;
  logic slot_free;
  logic walking;
  logic advance;
  logic out_load;

  assign s_tready  = (st == ST_IDLE);
  assign in_acc    = s_tvalid && s_tready;
  assign which     = s_tuser[0];
  assign has_term  = s_tuser[1];
  assign wr_a      = in_acc && has_term && !which && (cnt_a < CW'(DEPTH));
  assign wr_b      = in_acc && has_term && which && (cnt_b < CW'(DEPTH));
  assign slot_free = !out_valid || m_tready;

  assign head_a.avail = i < cnt_a;
  assign head_a.coef  = rd_a[spadd_pkg::COEF_W-1:0];
  assign head_a.expo  = rd_a[CE-1:spadd_pkg::COEF_W];
  assign head_b.avail = j < cnt_b;
  assign head_b.coef  = rd_b[spadd_pkg::COEF_W-1:0];
  assign head_b.expo  = rd_b[CE-1:spadd_pkg::COEF_W];

  spadd_step u_step (
    .head_a (head_a),
    .head_b (head_b),
    .step   (step)
  );

  assign walking = (st == ST_MERGE) && (head_a.avail || head_b.avail);
  assign advance = walking && !(step.nonzero && pend_valid && !slot_free);
  assign out_load = (advance && step.nonzero && pend_valid) ||
                    ((st == ST_FINISH) && slot_free);

  always_comb begin
    i_next = '0;
    j_next = '0;
    if (st == ST_MERGE) begin
      i_next = i + CW'(advance && step.take_a);
      j_next = j + CW'(advance && step.take_b);
    end
  end

  // list storage with registered head reads
  always_ff @(posedge clk) begin
    if (wr_a) begin
      mem_a[cnt_a[IW-1:0]] <= s_tdata[CE-1:0];
    end
    rd_a <= mem_a[i_next[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (wr_b) begin
      mem_b[cnt_b[IW-1:0]] <= s_tdata[CE-1:0];
    end
    rd_b <= mem_b[j_next[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st         <= ST_IDLE;
      cnt_a      <= '0;
      cnt_b      <= '0;
      i          <= '0;
      j          <= '0;
      dropped    <= 1'b0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
      i <= i_next;
      j <= j_next;
      unique case (st)
        ST_IDLE: begin
          if (in_acc) begin
            if (wr_a) begin
              cnt_a <= cnt_a + CW'(1);
            end
            if (wr_b) begin
              cnt_b <= cnt_b + CW'(1);
            end
            if (has_term && !wr_a && !wr_b) begin
              dropped <= 1'b1;
            end
            if (s_tlast) begin
              st <= ST_PREP;
            end
          end
        end
        ST_PREP: begin
          st <= ST_MERGE;
        end
        ST_MERGE: begin
          if (!walking) begin
            st <= ST_FINISH;
          end else if (advance && step.nonzero) begin
            pend_valid <= 1'b1;
            pend_coef  <= step.coef;
            pend_exp   <= step.expo;
            if (pend_valid) begin
              out_coef  <= pend_coef;
              out_exp   <= pend_exp;
              out_last  <= 1'b0;
              out_empty <= 1'b0;
              out_ovf   <= dropped;
            end
          end
        end
        ST_FINISH: begin
          if (slot_free) begin
            out_coef   <= pend_valid ? pend_coef : '0;
            out_exp    <= pend_valid ? pend_exp : '0;
            out_last   <= 1'b1;
            out_empty  <= !pend_valid;
            out_ovf    <= dropped;
            pend_valid <= 1'b0;
            cnt_a      <= '0;
            cnt_b      <= '0;
            dropped    <= 1'b0;
            st         <= ST_IDLE;
          end
        end
        default: begin
          st <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_exp, out_coef};
  assign m_tuser  = {out_ovf, out_empty};
  assign m_tlast  = out_last;

endmodule

// ===== rtl/spadd_step.sv =====
module spadd_step (
  input  spadd_pkg::head_t head_a,
  input  spadd_pkg::head_t head_b,
  output spadd_pkg::step_t step
);

  logic a_gt;
  logic b_gt;
  logic signed [spadd_pkg::SUM_W-1:0] ca;
  logic signed [spadd_pkg::SUM_W-1:0] cb;

  assign a_gt = head_a.expo > head_b.expo;
  assign b_gt = head_b.expo > head_a.expo;
  assign ca   = spadd_pkg::SUM_W'(head_a.coef);
  assign cb   = spadd_pkg::SUM_W'(head_b.coef);

  always_comb begin
    step = '0;
    if (!head_b.avail || (head_a.avail && a_gt)) begin
      step.take_a = head_a.avail;
      step.coef   = ca;
      step.expo   = head_a.expo;
    end else if (!head_a.avail || b_gt) begin
      step.take_b = 1'b1;
      step.coef   = cb;
      step.expo   = head_b.expo;
    end else begin
      step.take_a = 1'b1;
      step.take_b = 1'b1;
      step.coef   = ca + cb;
      step.expo   = head_a.expo;
    end
    step.nonzero = (step.take_a || step.take_b) && (step.coef != '0);
  end

endmodule
